// ----- hdl/xor_checksum_frame_parser_macros.svh -----
// ----------------------------------------------------------------------------
// xor_checksum_frame_parser_macros
// Assertion macros used by the checker file of the frame parser.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKSUM_FRAME_PARSER_MACROS_SVH
`define XOR_CHECKSUM_FRAME_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define XCFP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define XCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/xcfp_pkg.sv -----
// ----------------------------------------------------------------------------
// xcfp_pkg
// Constants, codes and controller/datapath interface types of the parser.
// ----------------------------------------------------------------------------
package xcfp_pkg;

  localparam int MAX_DATA = 32;
  localparam int ADDR_W   = $clog2(MAX_DATA);

  localparam logic [7:0] SOF_BYTE = 8'hAA;
  localparam logic [7:0] MAX_LEN  = 8'(MAX_DATA + 1);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_CSUM = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;

  typedef enum logic [5:0] {
    S_HUNT     = 6'b000001,
    S_LEN      = 6'b000010,
    S_PAYLOAD  = 6'b000100,
    S_CHECK    = 6'b001000,
    S_DRAIN_RD = 6'b010000,
    S_DRAIN_WR = 6'b100000
  } state_t;

  typedef struct packed {
    logic take_len;
    logic take_payload;
    logic emit_len_err;
    logic emit_csum_err;
    logic emit_ok_single;
    logic drain_start;
    logic drain_read;
    logic drain_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_sof;
    logic len_bad;
    logic payload_last;
    logic csum_ok;
    logic count_zero;
    logic drain_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hdl/xcfp_ctrl.sv -----
// ----------------------------------------------------------------------------
// xcfp_ctrl
// Frame phase sequencer: hunt, length, payload, checksum and data drain.
// ----------------------------------------------------------------------------
module xcfp_ctrl
  import xcfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     rx_valid,
  output logic     rx_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    rx_stall   = 1'b1;
    case (state)
      S_HUNT:    rx_stall = 1'b0;
      S_LEN:     rx_stall = !stat.out_free;
      S_PAYLOAD: rx_stall = 1'b0;
      S_CHECK:   rx_stall = !stat.out_free;
      default:   rx_stall = 1'b1;
    endcase
  end

  assign accept = rx_valid && !rx_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_HUNT: begin
        if (accept && stat.is_sof) state_next = S_LEN;
      end
      S_LEN: begin
        if (accept) begin
          if (stat.len_bad) begin
            cmd.emit_len_err = 1'b1;
            state_next       = S_HUNT;
          end else begin
            cmd.take_len = 1'b1;
            state_next   = S_PAYLOAD;
          end
        end
      end
      S_PAYLOAD: begin
        if (accept) begin
          cmd.take_payload = 1'b1;
          if (stat.payload_last) state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (accept) begin
          state_next = S_HUNT;
          if (!stat.csum_ok) begin
            cmd.emit_csum_err = 1'b1;
          end else if (stat.count_zero) begin
            cmd.emit_ok_single = 1'b1;
          end else begin
            cmd.drain_start = 1'b1;
            state_next      = S_DRAIN_RD;
          end
        end
      end
      S_DRAIN_RD: begin
        cmd.drain_read = 1'b1;
        state_next     = S_DRAIN_WR;
      end
      S_DRAIN_WR: begin
        if (stat.out_free) begin
          cmd.drain_emit = 1'b1;
          state_next     = stat.drain_last ? S_HUNT : S_DRAIN_RD;
        end
      end
      default: state_next = S_HUNT;
    endcase
  end

endmodule

// ----- hdl/xcfp_datapath.sv -----
// ----------------------------------------------------------------------------
// xcfp_datapath
// Length, count and XOR registers, data store and the result register.
// ----------------------------------------------------------------------------
module xcfp_datapath
  import xcfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic [7:0]  command,
  output logic [5:0]  data_count,
  output logic [4:0]  data_index,
  output logic [7:0]  data_value,
  output logic        last
);

  logic [5:0]        frame_length;
  logic [5:0]        bytes_seen;
  logic [7:0]        running_xor;
  logic [7:0]        frame_command;
  logic [ADDR_W-1:0] drain_idx;
  logic [7:0]        rd_data;
  logic [7:0]        store [MAX_DATA];
  logic [5:0]        frame_count;
  logic [5:0]        wr_pos;

  assign frame_count = frame_length - 6'd1;
  assign wr_pos      = bytes_seen - 6'd1;

  assign stat.is_sof       = (rx_byte == SOF_BYTE);
  assign stat.len_bad      = (rx_byte == 8'd0) || (rx_byte > MAX_LEN);
  assign stat.payload_last = ((bytes_seen + 6'd1) >= frame_length);
  assign stat.csum_ok      = (rx_byte == running_xor);
  assign stat.count_zero   = (frame_length == 6'd1);
  assign stat.drain_last   = ((6'(drain_idx) + 6'd1) == frame_count);
  assign stat.out_free     = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (cmd.take_len) begin
      frame_length <= rx_byte[5:0];
      bytes_seen   <= 6'd0;
      running_xor  <= rx_byte;
    end
    if (cmd.take_payload) begin
      if (bytes_seen == 6'd0) begin
        frame_command <= rx_byte;
      end
      running_xor <= running_xor ^ rx_byte;
      bytes_seen  <= bytes_seen + 6'd1;
    end
    if (cmd.drain_start) begin
      drain_idx <= '0;
    end else if (cmd.drain_emit) begin
      drain_idx <= drain_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_payload && (bytes_seen != 6'd0)) begin
      store[wr_pos[ADDR_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_read) begin
      rd_data <= store[drain_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit_len_err || cmd.emit_csum_err || cmd.emit_ok_single ||
                 cmd.drain_emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_len_err || cmd.emit_csum_err) begin
      status     <= cmd.emit_len_err ? ST_LEN : ST_CSUM;
      command    <= 8'd0;
      data_count <= 6'd0;
      data_index <= 5'd0;
      data_value <= 8'd0;
      last       <= 1'b1;
    end else if (cmd.emit_ok_single) begin
      status     <= ST_OK;
      command    <= frame_command;
      data_count <= 6'd0;
      data_index <= 5'd0;
      data_value <= 8'd0;
      last       <= 1'b1;
    end else if (cmd.drain_emit) begin
      status     <= ST_OK;
      command    <= frame_command;
      data_count <= frame_count;
      data_index <= 5'(drain_idx);
      data_value <= rd_data;
      last       <= stat.drain_last;
    end
  end

endmodule

// ----- hdl/xor_checksum_frame_parser.sv -----
// ----------------------------------------------------------------------------
// xor_checksum_frame_parser
// Start byte / length / XOR checksum frame parser, one received byte a beat.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while hunting for the start byte and while the
// payload streams in. The length and checksum beats wait only while a result
// in the output register is stalled. After a good frame with N data bytes the
// input stalls while the data store is read out, each data byte taking a read
// state and then a write state for the registered read port of the store, and
// while the result side stalls. A frame with no data, a bad length or a bad
// checksum gives one result and stalls nothing.
module xor_checksum_frame_parser
  import xcfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] status,
  output logic [7:0] command,
  output logic [5:0] data_count,
  output logic [4:0] data_index,
  output logic [7:0] data_value,
  output logic       last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  xcfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  xcfp_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (rx_byte),
    .cmd        (cmd),
    .stat       (stat),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .status     (status),
    .command    (command),
    .data_count (data_count),
    .data_index (data_index),
    .data_value (data_value),
    .last       (last)
  );

endmodule

// ----- hdl/xcfp_checker.sv -----
// ----------------------------------------------------------------------------
// xcfp_checker
// Port-level checks of the frame parser results, bound to the top level.
// ----------------------------------------------------------------------------
`include "xor_checksum_frame_parser_macros.svh"

module xcfp_checker
  import xcfp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic [1:0] status,
  input logic [7:0] command,
  input logic [5:0] data_count,
  input logic [4:0] data_index,
  input logic [7:0] data_value,
  input logic       last
);

  `XCFP_ASSERT_NEXT(a_hold, res_valid && res_stall, res_valid && $stable(status) && $stable(data_index) && $stable(data_value) && $stable(last), "result beat changed while stalled")
  `XCFP_ASSERT_IMPL(a_err_last, res_valid && (status != ST_OK), last && (command == 8'd0) && (data_count == 6'd0) && (data_value == 8'd0), "error beat not a lone zeroed result")
  `XCFP_ASSERT_IMPL(a_mid_index, res_valid && (status == ST_OK) && !last, (6'(data_index) + 6'd1) < data_count, "non-final beat index out of range")
  `XCFP_ASSERT_IMPL(a_last_index, res_valid && (status == ST_OK) && last && (data_count != 6'd0), (6'(data_index) + 6'd1) == data_count, "final beat index does not close the frame")

endmodule

bind xor_checksum_frame_parser xcfp_checker u_xcfp_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .status     (status),
  .command    (command),
  .data_count (data_count),
  .data_index (data_index),
  .data_value (data_value),
  .last       (last)
);

// ----- bench/xor_checksum_frame_parser_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_checksum_frame_parser_checker
// Watches both channels of the frame parser, predicts and compares results.
// ----------------------------------------------------------------------------
// Every byte beat taken on the receive side runs through a behavioral copy of
// the parser: start byte hunt, length, command and data payload, checksum.
// The results it predicts wait in order; every result beat is checked field
// by field against the oldest one. Mismatches and results that nobody
// expected are counted; the number still waiting is shown to the top.
module xor_checksum_frame_parser_checker
  import xcfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  input  logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       res_valid,
  input  logic       res_stall,
  input  logic [1:0] status,
  input  logic [7:0] command,
  input  logic [5:0] data_count,
  input  logic [4:0] data_index,
  input  logic [7:0] data_value,
  input  logic       last,
  output int         mismatches,
  output int         outstanding
);

  typedef enum logic [1:0] {
    P_HUNT,
    P_LEN,
    P_PAYLOAD,
    P_CHECK
  } rx_phase_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] command;
    logic [5:0] count;
    logic [4:0] index;
    logic [7:0] value;
    logic       last;
  } frame_result_t;

  rx_phase_t     phase;
  logic [5:0]    frame_len;
  logic [5:0]    payload_seen;
  logic [7:0]    running_xor;
  logic [7:0]    frame_cmd;
  logic [7:0]    data_bytes [MAX_DATA];
  frame_result_t expected_results [$];

  task automatic push_result(input logic [1:0] st, input logic [7:0] cmd,
                             input logic [5:0] cnt, input logic [4:0] idx,
                             input logic [7:0] val, input logic lst);
    frame_result_t r;
    r.status  = st;
    r.command = cmd;
    r.count   = cnt;
    r.index   = idx;
    r.value   = val;
    r.last    = lst;
    expected_results.push_back(r);
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [5:0] n_data;
    case (phase)
      P_HUNT: begin
        if (b == SOF_BYTE) phase = P_LEN;
      end
      P_LEN: begin
        if (b == 8'd0 || b > MAX_LEN) begin
          push_result(ST_LEN, 8'd0, 6'd0, 5'd0, 8'd0, 1'b1);
          phase = P_HUNT;
        end else begin
          frame_len    = 6'(b);
          payload_seen = 6'd0;
          running_xor  = b;
          phase        = P_PAYLOAD;
        end
      end
      P_PAYLOAD: begin
        if (payload_seen == 6'd0) frame_cmd = b;
        else data_bytes[ADDR_W'(payload_seen - 6'd1)] = b;
        running_xor  = running_xor ^ b;
        payload_seen = payload_seen + 6'd1;
        if (payload_seen >= frame_len) phase = P_CHECK;
      end
      default: begin
        phase = P_HUNT;
        n_data = frame_len - 6'd1;
        if (b != running_xor) begin
          push_result(ST_CSUM, 8'd0, 6'd0, 5'd0, 8'd0, 1'b1);
        end else if (n_data == 6'd0) begin
          push_result(ST_OK, frame_cmd, 6'd0, 5'd0, 8'd0, 1'b1);
        end else begin
          for (int k = 0; k < int'(n_data); k++) begin
            push_result(ST_OK, frame_cmd, n_data, 5'(k), data_bytes[k],
                        (k + 1 == int'(n_data)));
          end
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic compare_result();
    frame_result_t exp_r;
    if (expected_results.size() == 0) begin
      $error("result beat with none expected: status %0d command 0x%0h last %0b",
             status, command, last);
      mismatches++;
      return;
    end
    exp_r = expected_results.pop_front();
    compare_field("status", 8'(exp_r.status), 8'(status));
    compare_field("command", exp_r.command, command);
    compare_field("data_count", 8'(exp_r.count), 8'(data_count));
    compare_field("data_index", 8'(exp_r.index), 8'(data_index));
    compare_field("data_value", exp_r.value, data_value);
    compare_field("last", 8'(exp_r.last), 8'(last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase        = P_HUNT;
      frame_len    = 6'd0;
      payload_seen = 6'd0;
      running_xor  = 8'd0;
      frame_cmd    = 8'd0;
      mismatches   = 0;
      expected_results.delete();
    end else begin
      if (rx_valid && !rx_stall) parse_rx_byte(rx_byte);
      if (res_valid && !res_stall) compare_result();
    end
    outstanding = expected_results.size();
  end

endmodule

// ----- bench/xor_checksum_frame_parser_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_checksum_frame_parser_tb
// Stimulus and verdict for the start byte / length / XOR checksum parser.
// ----------------------------------------------------------------------------
// A short directed run covers noise while hunting, lengths out of range at
// both ends, a frame with no data, the start byte inside a frame and a bad
// checksum. Random frames follow, mostly well formed with random content and
// lengths, mixed with bad checksums, bad lengths and stray bytes. The sender
// idles in random bursts, the result side stalls in changing patterns, and
// the checker beside the parser predicts and compares every result beat.
module xor_checksum_frame_parser_tb;
  import xcfp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 370;

  logic       clk = 1'b0;
  logic       rst;
  logic       rx_valid;
  logic       rx_stall;
  logic [7:0] rx_byte;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [1:0] status;
  logic [7:0] command;
  logic [5:0] data_count;
  logic [4:0] data_index;
  logic [7:0] data_value;
  logic       last;
  int         mismatches;
  int         outstanding;

  int         cycle_count;
  int         frame_items;
  int         burst_left;
  bit         gaps_on;
  int         stall_mode = 0;
  int         window_left = 0;
  logic [7:0] frame_payload [$];

  always #6 clk = ~clk;

  xor_checksum_frame_parser u_top (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .status     (status),
    .command    (command),
    .data_count (data_count),
    .data_index (data_index),
    .data_value (data_value),
    .last       (last)
  );

  xor_checksum_frame_parser_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .status      (status),
    .command     (command),
    .data_count  (data_count),
    .data_index  (data_index),
    .data_value  (data_value),
    .last        (last),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (window_left <= 0) begin
      stall_mode  <= $urandom_range(0, 2);
      window_left <= $urandom_range(50, 300);
    end else begin
      window_left <= window_left - 1;
    end
    case (stall_mode)
      0:       res_stall <= 1'b0;
      1:       res_stall <= ($urandom_range(0, 3) == 0);
      default: res_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    bit taken;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        rx_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do begin
      @(negedge clk);
      taken = !rx_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_frame(input bit bad_sum);
    logic [7:0] sum;
    sum = 8'(frame_payload.size());
    send_byte(SOF_BYTE);
    send_byte(8'(frame_payload.size()));
    foreach (frame_payload[i]) begin
      sum = sum ^ frame_payload[i];
      send_byte(frame_payload[i]);
    end
    send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    frame_items += frame_payload.size() + 3;
  endtask

  task automatic send_bad_length(input logic [7:0] len);
    send_byte(SOF_BYTE);
    send_byte(len);
    frame_items += 2;
  endtask

  task automatic drain_results();
    rx_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int  pick;
    int  len;
    bit  paused;
    rst         <= 1'b1;
    rx_valid    <= 1'b0;
    rx_byte     <= 8'd0;
    frame_items = 0;
    burst_left  = 0;
    gaps_on     = 1'b0;
    paused      = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_bad_length(8'h00);
    send_bad_length(MAX_LEN + 8'd1);
    send_bad_length(8'hFF);
    frame_payload = '{8'hFF};
    send_frame(1'b0);
    frame_payload = '{SOF_BYTE, 8'h00, 8'hFF};
    send_frame(1'b0);
    frame_payload = '{8'h00};
    send_frame(1'b1);

    while (frame_items < ITEM_TARGET) begin
      pick    = $urandom_range(0, 99);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (pick < 84) begin
        len = $urandom_range(0, 99);
        if (len < 60) len = $urandom_range(1, 4);
        else if (len < 90) len = $urandom_range(5, 12);
        else if (len < 96) len = $urandom_range(13, MAX_DATA);
        else len = MAX_DATA + 1;
        frame_payload.delete();
        repeat (len) frame_payload.push_back(8'($urandom));
        send_frame(pick >= 72);
      end else if (pick < 90) begin
        if ($urandom_range(0, 1) == 0) send_bad_length(8'h00);
        else send_bad_length(8'($urandom_range(int'(MAX_LEN) + 1, 255)));
      end else begin
        if ($urandom_range(0, 3) == 0) send_byte(SOF_BYTE);
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
      if (!paused && frame_items > ITEM_TARGET / 2) begin
        drain_results();
        repeat ($urandom_range(5, 20)) @(posedge clk);
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
